/* hw/rtl/cte_pkg.sv */
// Shared types and codes for the cell-to-ANSI truecolor encoder.
package cte_pkg;

    // Default depth of the command queue between the front and back parts
    localparam int unsigned QUEUE_DEPTH = 2;

    // Input function codes
    localparam logic [1:0] FUNC_BEGIN  = 2'd0;
    localparam logic [1:0] FUNC_CELL   = 2'd1;
    localparam logic [1:0] FUNC_FINISH = 2'd2;

    // Cursor shape codes
    localparam logic [1:0] SHAPE_BLOCK = 2'd1;
    localparam logic [1:0] SHAPE_BAR   = 2'd2;

    // One-based coordinate, 1..1024
    typedef logic [10:0] t_coord;

    // Classified command handed from the front part to the back part
    typedef struct packed {
        logic [1:0]  func;
        logic        emit_fg;
        logic        emit_bg;
        logic [7:0]  ch;
        logic [23:0] fg;
        logic [23:0] bg;
        logic        shape_on;
        logic        shape_bar;
        t_coord      row1;
        t_coord      col1;
    } t_cmd;

endpackage

/* hw/rtl/cte_front.sv */
// Front part: accepts input items, tracks color state and classifies each item.
module cte_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [1:0]      i_func,
    input  logic [7:0]      i_ch,
    input  logic [23:0]     i_fg_color,
    input  logic [23:0]     i_bg_color,
    input  logic [1:0]      i_cursor_shape,
    input  logic [9:0]      i_cursor_col,
    input  logic [9:0]      i_cursor_row,
    input  logic            i_full,
    output logic            o_push,
    output cte_pkg::t_cmd   o_cmd
);

    logic [23:0] r_prev_fg;
    logic [23:0] r_prev_bg;
    logic        r_force;
    logic [23:0] n_prev_fg;
    logic [23:0] n_prev_bg;
    logic        n_force;
    logic        accept;
    logic        is_begin;
    logic        is_cell;
    logic        is_finish;

    // Accept whenever the queue has room
    assign o_ready   = !i_full;
    assign accept    = i_valid && o_ready;
    assign is_begin  = (i_func == cte_pkg::FUNC_BEGIN);
    assign is_cell   = (i_func == cte_pkg::FUNC_CELL);
    assign is_finish = (i_func == cte_pkg::FUNC_FINISH);

    // Drop unused function codes, queue everything else
    assign o_push = accept && (is_begin || is_cell || is_finish);

    // Classify the item
    always_comb begin
        o_cmd.func      = i_func;
        o_cmd.emit_fg   = r_force || (i_fg_color != r_prev_fg);
        o_cmd.emit_bg   = r_force || (i_bg_color != r_prev_bg);
        o_cmd.ch        = i_ch;
        o_cmd.fg        = i_fg_color;
        o_cmd.bg        = i_bg_color;
        o_cmd.shape_on  = (i_cursor_shape == cte_pkg::SHAPE_BLOCK) ||
                          (i_cursor_shape == cte_pkg::SHAPE_BAR);
        o_cmd.shape_bar = (i_cursor_shape == cte_pkg::SHAPE_BAR);
        o_cmd.row1      = {1'b0, i_cursor_row} + 11'd1;
        o_cmd.col1      = {1'b0, i_cursor_col} + 11'd1;
    end

    // Update color state on accepted items
    always_comb begin
        n_prev_fg = r_prev_fg;
        n_prev_bg = r_prev_bg;
        n_force   = r_force;
        if (accept && is_cell) begin
            n_prev_fg = i_fg_color;
            n_prev_bg = i_bg_color;
            n_force   = 1'b0;
        end else if (accept && is_begin) begin
            n_force   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_fg <= 24'd0;
            r_prev_bg <= 24'd0;
            r_force   <= 1'b1;
        end else begin
            r_prev_fg <= n_prev_fg;
            r_prev_bg <= n_prev_bg;
            r_force   <= n_force;
        end
    end

    a_cell_clears_force: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_cell) |=> !r_force)
        else $error("force flag still set after a cell item");

    a_begin_sets_force: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_begin) |=> (r_force && $stable(r_prev_fg) && $stable(r_prev_bg)))
        else $error("begin item did not force colors or changed color state");

endmodule

/* hw/rtl/cte_fifo.sv */
// Short command queue between the front and back parts.
module cte_fifo #(
    parameter int unsigned DEPTH = cte_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cte_pkg::t_cmd   i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output cte_pkg::t_cmd   o_cmd,
    output logic            o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    cte_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // Advance pointers with wrap at the depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store pushed items
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into a full command queue");

endmodule

/* hw/rtl/cte_back.sv */
// Back part: sequences the escape bytes of each command into the output register.
module cte_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cte_pkg::t_cmd   i_cmd,
    input  logic            i_empty,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_last_byte
);

    // Segment codes, in emission order
    localparam logic [2:0] SEG_CLEAR = 3'd0;
    localparam logic [2:0] SEG_FG    = 3'd1;
    localparam logic [2:0] SEG_BG    = 3'd2;
    localparam logic [2:0] SEG_CHAR  = 3'd3;
    localparam logic [2:0] SEG_SHAPE = 3'd4;
    localparam logic [2:0] SEG_MOVE  = 3'd5;

    // Characters
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_LBR   = 8'h5B;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_2     = 8'h32;
    localparam logic [7:0] CH_3     = 8'h33;
    localparam logic [7:0] CH_4     = 8'h34;
    localparam logic [7:0] CH_6     = 8'h36;
    localparam logic [7:0] CH_8     = 8'h38;
    localparam logic [7:0] CH_UP_H  = 8'h48;
    localparam logic [7:0] CH_UP_J  = 8'h4A;
    localparam logic [7:0] CH_LO_M  = 8'h6D;
    localparam logic [7:0] CH_LO_Q  = 8'h71;

    // Decimal place value
    function automatic logic [13:0] place_value(input logic [1:0] place);
        logic [13:0] pv;
        unique case (place)
            2'd0: pv = 14'd1;
            2'd1: pv = 14'd10;
            2'd2: pv = 14'd100;
            2'd3: pv = 14'd1000;
            default: pv = 14'd1;
        endcase
        return pv;
    endfunction

    // First segment of a command
    function automatic logic [2:0] first_seg(input cte_pkg::t_cmd c);
        logic [2:0] s;
        priority if (c.func == cte_pkg::FUNC_BEGIN) begin
            s = SEG_CLEAR;
        end else if (c.func == cte_pkg::FUNC_CELL) begin
            s = c.emit_fg ? SEG_FG : (c.emit_bg ? SEG_BG : SEG_CHAR);
        end else begin
            s = c.shape_on ? SEG_SHAPE : SEG_MOVE;
        end
        return s;
    endfunction

    logic                r_busy;
    cte_pkg::t_cmd       r_cmd;
    logic [2:0]          r_seg;
    logic [3:0]          r_pc;
    logic                r_numact;
    logic [10:0]         r_num;
    logic [1:0]          r_place;
    logic                r_out_valid;
    logic [7:0]          r_out_byte;
    logic                r_out_last;

    logic [7:0]          step_byte;
    logic                step_is_num;
    logic [10:0]         step_num;
    logic                step_seg_end;
    logic [7:0]          sgr_kind;
    logic [23:0]         sgr_color;
    logic [10:0]         num_val;
    logic [1:0]          first_place;
    logic [1:0]          cur_place;
    logic [13:0]         cur_pv;
    logic [3:0]          digit;
    logic [13:0]         digit_sub;
    logic [10:0]         remainder;
    logic                num_done;
    logic                seg_end_now;
    logic                final_seg;
    logic                item_done;
    logic                out_free;
    logic                advance;
    logic [2:0]          next_seg;
    logic [7:0]          emit_byte;

    // Select the current step of the segment
    always_comb begin
        sgr_kind     = (r_seg == SEG_FG) ? CH_3 : CH_4;
        sgr_color    = (r_seg == SEG_FG) ? r_cmd.fg : r_cmd.bg;
        step_byte    = CH_ESC;
        step_is_num  = 1'b0;
        step_num     = 11'd0;
        step_seg_end = 1'b0;
        unique case (r_seg)
            SEG_CLEAR: begin
                unique case (r_pc)
                    4'd0: step_byte = CH_ESC;
                    4'd1: step_byte = CH_LBR;
                    4'd2: step_byte = CH_2;
                    4'd3: step_byte = CH_UP_J;
                    4'd4: step_byte = CH_ESC;
                    4'd5: step_byte = CH_LBR;
                    4'd6: step_byte = CH_1;
                    4'd7: step_byte = CH_SEMI;
                    4'd8: step_byte = CH_1;
                    default: begin
                        step_byte    = CH_UP_H;
                        step_seg_end = 1'b1;
                    end
                endcase
            end
            SEG_FG, SEG_BG: begin
                unique case (r_pc)
                    4'd0: step_byte = CH_ESC;
                    4'd1: step_byte = CH_LBR;
                    4'd2: step_byte = sgr_kind;
                    4'd3: step_byte = CH_8;
                    4'd4: step_byte = CH_SEMI;
                    4'd5: step_byte = CH_2;
                    4'd6: step_byte = CH_SEMI;
                    4'd7: begin
                        step_is_num = 1'b1;
                        step_num    = {3'b0, sgr_color[23:16]};
                    end
                    4'd8: step_byte = CH_SEMI;
                    4'd9: begin
                        step_is_num = 1'b1;
                        step_num    = {3'b0, sgr_color[15:8]};
                    end
                    4'd10: step_byte = CH_SEMI;
                    4'd11: begin
                        step_is_num = 1'b1;
                        step_num    = {3'b0, sgr_color[7:0]};
                    end
                    default: begin
                        step_byte    = CH_LO_M;
                        step_seg_end = 1'b1;
                    end
                endcase
            end
            SEG_CHAR: begin
                step_byte    = r_cmd.ch;
                step_seg_end = 1'b1;
            end
            SEG_SHAPE: begin
                unique case (r_pc)
                    4'd0: step_byte = CH_ESC;
                    4'd1: step_byte = CH_LBR;
                    4'd2: step_byte = r_cmd.shape_bar ? CH_6 : CH_2;
                    4'd3: step_byte = CH_SPACE;
                    default: begin
                        step_byte    = CH_LO_Q;
                        step_seg_end = 1'b1;
                    end
                endcase
            end
            default: begin
                unique case (r_pc)
                    4'd0: step_byte = CH_ESC;
                    4'd1: step_byte = CH_LBR;
                    4'd2: begin
                        step_is_num = 1'b1;
                        step_num    = r_cmd.row1;
                    end
                    4'd3: step_byte = CH_SEMI;
                    4'd4: begin
                        step_is_num = 1'b1;
                        step_num    = r_cmd.col1;
                    end
                    default: begin
                        step_byte    = CH_UP_H;
                        step_seg_end = 1'b1;
                    end
                endcase
            end
        endcase
    end

    // One decimal digit per cycle while output is free, most significant first
    always_comb begin
        num_val = r_numact ? r_num : step_num;
        priority if (step_num >= 11'd1000) begin
            first_place = 2'd3;
        end else if (step_num >= 11'd100) begin
            first_place = 2'd2;
        end else if (step_num >= 11'd10) begin
            first_place = 2'd1;
        end else begin
            first_place = 2'd0;
        end
        cur_place = r_numact ? r_place : first_place;
        cur_pv    = place_value(cur_place);
        digit     = 4'd0;
        digit_sub = 14'd0;
        for (int k = 1; k < 10; k++) begin
            if ({3'b0, num_val} >= 14'(k) * cur_pv) begin
                digit     = 4'(k);
                digit_sub = 14'(k) * cur_pv;
            end
        end
        remainder = num_val - digit_sub[10:0];
        num_done  = (cur_place == 2'd0);
    end

    // Sequencing decisions
    always_comb begin
        emit_byte   = step_is_num ? (CH_0 + {4'b0, digit}) : step_byte;
        seg_end_now = step_seg_end && (!step_is_num || num_done);
        final_seg   = (r_seg == SEG_CLEAR) || (r_seg == SEG_CHAR) || (r_seg == SEG_MOVE);
        out_free    = !r_out_valid || i_ready;
        advance     = r_busy && out_free;
        item_done   = advance && seg_end_now && final_seg;
        o_pop       = !i_empty && (!r_busy || item_done);
        unique case (r_seg)
            SEG_FG:    next_seg = r_cmd.emit_bg ? SEG_BG : SEG_CHAR;
            SEG_SHAPE: next_seg = SEG_MOVE;
            default:   next_seg = SEG_CHAR;
        endcase
    end

    // Load commands and step through their bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_numact <= 1'b0;
            r_seg    <= SEG_CLEAR;
            r_pc     <= 4'd0;
        end else if (o_pop) begin
            r_busy   <= 1'b1;
            r_numact <= 1'b0;
            r_seg    <= first_seg(i_cmd);
            r_pc     <= 4'd0;
        end else if (advance) begin
            if (step_is_num && !num_done) begin
                r_numact <= 1'b1;
            end else begin
                r_numact <= 1'b0;
                if (!seg_end_now) begin
                    r_pc <= r_pc + 4'd1;
                end else if (final_seg) begin
                    r_busy <= 1'b0;
                end else begin
                    r_seg <= next_seg;
                    r_pc  <= 4'd0;
                end
            end
        end
    end

    // Hold the command and the running number
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (advance && step_is_num && !num_done) begin
            r_num   <= remainder;
            r_place <= cur_place - 2'd1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_byte <= emit_byte;
            r_out_last <= seg_end_now && final_seg;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last_byte = r_out_last;

    a_remainder_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_numact) |-> ({3'b0, r_num} < place_value(r_place + 2'd1)))
        else $error("decimal remainder exceeds its place");

    a_number_holds_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_numact) |-> step_is_num)
        else $error("number printing left its step before the last digit");

endmodule

/* hw/rtl/cell_to_ansi_truecolor_encoder.sv */
// Top level of the cell-to-ANSI truecolor encoder.
//
// Input channel (i_valid / o_ready) takes one item per cycle while the command
// queue has room: begin frame, cell, or finish frame with cursor. Output channel
// (o_valid / i_ready) gives one byte of the terminal stream per cycle while the
// receiver is ready, with o_last_byte high on the final byte caused by an item.
// Items with the unused function code produce no bytes.
// The first byte of an item passes from the command queue into the back
// part's command register and then into the output register. The back part
// emits one byte per cycle while the receiver is ready; an item has one byte
// for a cell whose colors repeat, up to 39 for a cell that re-sends both
// colors, and 10 for a begin item. The byte sequencer is the limit; the front
// part accepts an item every cycle while the command queue has room.
// Reset (synchronous, active low) empties the queue and the output
// register, clears the previous colors to zero and forces color codes on
// the next cell. When the receiver stalls, the output byte holds, the back
// part stops, and the queue fills until o_ready drops.
module cell_to_ansi_truecolor_encoder #(
    parameter int unsigned QUEUE_DEPTH = cte_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_ch,
    input  logic [23:0] i_fg_color,
    input  logic [23:0] i_bg_color,
    input  logic [1:0]  i_cursor_shape,
    input  logic [9:0]  i_cursor_col,
    input  logic [9:0]  i_cursor_row,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_last_byte
);

    cte_pkg::t_cmd push_cmd;
    cte_pkg::t_cmd head_cmd;
    logic          push;
    logic          pop;
    logic          full;
    logic          empty;

    // Accept and classify items
    cte_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_func         (i_func),
        .i_ch           (i_ch),
        .i_fg_color     (i_fg_color),
        .i_bg_color     (i_bg_color),
        .i_cursor_shape (i_cursor_shape),
        .i_cursor_col   (i_cursor_col),
        .i_cursor_row   (i_cursor_row),
        .i_full         (full),
        .o_push         (push),
        .o_cmd          (push_cmd)
    );

    // Decouple front and back
    cte_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (empty)
    );

    // Emit the bytes of each command
    cte_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (head_cmd),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte),
        .o_last_byte (o_last_byte)
    );

endmodule

/* verif/tb.sv */
// Self-checking testbench for the cell-to-ANSI truecolor encoder.
`timescale 1ns / 100ps

module tb;

    // Function code and shape codes that the package leaves unnamed
    localparam logic [1:0] FUNC_UNUSED  = 2'd3;
    localparam logic [1:0] SHAPE_NONE   = 2'd0;
    localparam logic [1:0] SHAPE_UNUSED = 2'd3;
    localparam logic [7:0] ESC          = 8'h1B;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned DRAIN_WAIT  = 16;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  ch;
        logic [23:0] fg;
        logic [23:0] bg;
        logic [1:0]  shape;
        logic [9:0]  col;
        logic [9:0]  row;
    } t_item;

    typedef struct packed {
        logic [7:0] data;
        logic       is_last;
    } t_out_byte;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_func;
    logic [7:0]  i_ch;
    logic [23:0] i_fg_color;
    logic [23:0] i_bg_color;
    logic [1:0]  i_cursor_shape;
    logic [9:0]  i_cursor_col;
    logic [9:0]  i_cursor_row;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_out_byte;
    logic        o_last_byte;

    // Encoder state as the predictor sees it
    logic [23:0] last_fg;
    logic [23:0] last_bg;
    logic        colors_forced;

    // Bytes of the item being predicted, and bytes still owed by the block
    logic [7:0]  stream_q[$];
    t_out_byte   pending_bytes_q[$];

    // Directed stimulus rows
    t_item       dir_items[$];
    bit          dir_typed[$];
    string       dir_want[$];

    int unsigned snd_idle_pct;
    int unsigned rcv_stall_pct;
    int unsigned err_count;
    int unsigned cycle_count;
    int unsigned items_sent;
    int unsigned frames_sent;
    int unsigned bytes_seen;
    logic [23:0] gen_fg;
    logic [23:0] gen_bg;

    cell_to_ansi_truecolor_encoder u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_func         (i_func),
        .i_ch           (i_ch),
        .i_fg_color     (i_fg_color),
        .i_bg_color     (i_bg_color),
        .i_cursor_shape (i_cursor_shape),
        .i_cursor_col   (i_cursor_col),
        .i_cursor_row   (i_cursor_row),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_byte     (o_out_byte),
        .o_last_byte    (o_last_byte)
    );

    always #1 i_clk = ~i_clk;

    // Count cycles and stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TIMEOUT after %0d cycles, %0d bytes still owed",
                     cycle_count, pending_bytes_q.size());
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        err_count++;
        $display("MISMATCH cycle %0d: %s", cycle_count, what);
    endtask

    // Output bytes in decimal, no leading zeros
    function automatic void put_dec(input int unsigned v);
        logic [7:0] digits[$];
        do begin
            digits.push_front(8'h30 + 8'(v % 10));
            v = v / 10;
        end while (v != 0);
        foreach (digits[k])
            stream_q.push_back(digits[k]);
    endfunction

    function automatic void put_csi();
        stream_q.push_back(ESC);
        stream_q.push_back("[");
    endfunction

    // SGR truecolor: kind "3" for foreground, "4" for background
    function automatic void put_color(input logic [7:0] kind, input logic [23:0] c);
        put_csi();
        stream_q.push_back(kind);
        stream_q.push_back("8");
        stream_q.push_back(";");
        stream_q.push_back("2");
        stream_q.push_back(";");
        put_dec({24'd0, c[23:16]});
        stream_q.push_back(";");
        put_dec({24'd0, c[15:8]});
        stream_q.push_back(";");
        put_dec({24'd0, c[7:0]});
        stream_q.push_back("m");
    endfunction

    // Compute the byte stream one item causes and advance the held state
    function automatic void encode_ansi(input t_item it);
        stream_q.delete();
        case (it.func)
            cte_pkg::FUNC_BEGIN: begin
                put_csi();
                stream_q.push_back("2");
                stream_q.push_back("J");
                put_csi();
                stream_q.push_back("1");
                stream_q.push_back(";");
                stream_q.push_back("1");
                stream_q.push_back("H");
                colors_forced = 1'b1;
            end
            cte_pkg::FUNC_CELL: begin
                if (colors_forced || it.fg != last_fg)
                    put_color("3", it.fg);
                if (colors_forced || it.bg != last_bg)
                    put_color("4", it.bg);
                stream_q.push_back(it.ch);
                last_fg       = it.fg;
                last_bg       = it.bg;
                colors_forced = 1'b0;
            end
            cte_pkg::FUNC_FINISH: begin
                if (it.shape == cte_pkg::SHAPE_BLOCK || it.shape == cte_pkg::SHAPE_BAR) begin
                    put_csi();
                    stream_q.push_back(it.shape == cte_pkg::SHAPE_BLOCK ? "2" : "6");
                    stream_q.push_back(" ");
                    stream_q.push_back("q");
                end
                put_csi();
                put_dec({22'd0, it.row} + 32'd1);
                stream_q.push_back(";");
                put_dec({22'd0, it.col} + 32'd1);
                stream_q.push_back("H");
            end
            FUNC_UNUSED: ;
        endcase
    endfunction

    task automatic add_row(input logic [1:0] func, input logic [7:0] ch,
                           input logic [23:0] fg, input logic [23:0] bg,
                           input logic [1:0] shape, input logic [9:0] col,
                           input logic [9:0] row, input bit typed, input string want);
        dir_items.push_back({func, ch, fg, bg, shape, col, row});
        dir_typed.push_back(typed);
        dir_want.push_back(want);
    endtask

    // Offer one item, hold it until accepted, then log its expected bytes
    task automatic drive_item(input t_item it, input bit typed, input string want);
        int n;
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            i_valid        <= 1'b0;
            i_func         <= 2'($urandom);
            i_ch           <= 8'($urandom);
            i_fg_color     <= 24'($urandom);
            i_bg_color     <= 24'($urandom);
            i_cursor_shape <= 2'($urandom);
            i_cursor_col   <= 10'($urandom);
            i_cursor_row   <= 10'($urandom);
            @(posedge i_clk);
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_func         <= it.func;
        i_ch           <= it.ch;
        i_fg_color     <= it.fg;
        i_bg_color     <= it.bg;
        i_cursor_shape <= it.shape;
        i_cursor_col   <= it.col;
        i_cursor_row   <= it.row;
        do @(posedge i_clk); while (!o_ready);
        encode_ansi(it);
        if (typed) begin
            stream_q.delete();
            for (n = 0; n < want.len(); n++)
                stream_q.push_back(want[n]);
        end
        n = stream_q.size();
        foreach (stream_q[k])
            pending_bytes_q.push_back('{data: stream_q[k], is_last: (k == n - 1)});
        if (it.func != FUNC_UNUSED)
            items_sent++;
        if (it.func == cte_pkg::FUNC_BEGIN)
            frames_sent++;
        @(negedge i_clk);
    endtask

    // Mostly repeat the last color, sometimes a boundary value, else anything
    function automatic logic [23:0] pick_color(input logic [23:0] prev);
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 11)
            return prev;
        case (r)
            11: return 24'h000000;
            12: return 24'hFFFFFF;
            13: return 24'h0A6309;
            14: return 24'h646464;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [9:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return 10'd0;
            1: return 10'd998;
            2: return 10'd1023;
            default: return 10'($urandom_range(0, 1023));
        endcase
    endfunction

    // Random frames with random content, mixed with stray and unused items
    task automatic run_random(input int unsigned n_items, input int unsigned snd_pct,
                              input int unsigned rcv_pct);
        int unsigned start;
        int unsigned cells;
        t_item       it;
        snd_idle_pct  = snd_pct;
        rcv_stall_pct = rcv_pct;
        start = items_sent;
        while (items_sent - start < n_items) begin
            it = {2'($urandom), 8'($urandom), 24'($urandom), 24'($urandom),
                  2'($urandom), 10'($urandom), 10'($urandom)};
            if ($urandom_range(0, 99) < 15) begin
                drive_item(it, 1'b0, "");
            end else begin
                it.func = cte_pkg::FUNC_BEGIN;
                drive_item(it, 1'b0, "");
                cells = $urandom_range(1, 12);
                repeat (cells) begin
                    it.func = cte_pkg::FUNC_CELL;
                    it.ch   = 8'($urandom);
                    gen_fg  = pick_color(gen_fg);
                    gen_bg  = pick_color(gen_bg);
                    it.fg   = gen_fg;
                    it.bg   = gen_bg;
                    drive_item(it, 1'b0, "");
                end
                it.func  = cte_pkg::FUNC_FINISH;
                it.shape = 2'($urandom_range(0, 3));
                it.col   = pick_coord();
                it.row   = pick_coord();
                drive_item(it, 1'b0, "");
            end
        end
    endtask

    // Receiver stalls at random
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end

    // Compare each accepted byte with the oldest one owed
    always @(posedge i_clk) begin : check_bytes
        t_out_byte want;
        if (i_rst_n && o_valid && i_ready) begin
            bytes_seen++;
            if (pending_bytes_q.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %02h last %0b",
                                          o_out_byte, o_last_byte));
            end else begin
                want = pending_bytes_q.pop_front();
                if (o_out_byte !== want.data)
                    report_mismatch($sformatf("byte %02h, want %02h",
                                              o_out_byte, want.data));
                if (o_last_byte !== want.is_last)
                    report_mismatch($sformatf("last_byte %0b, want %0b on byte %02h",
                                              o_last_byte, want.is_last, want.data));
            end
        end
    end

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_ready        = 1'b0;
        i_func         = cte_pkg::FUNC_BEGIN;
        i_ch           = 8'd0;
        i_fg_color     = 24'd0;
        i_bg_color     = 24'd0;
        i_cursor_shape = SHAPE_NONE;
        i_cursor_col   = 10'd0;
        i_cursor_row   = 10'd0;
        last_fg        = 24'd0;
        last_bg        = 24'd0;
        colors_forced  = 1'b1;
        snd_idle_pct   = 10;
        rcv_stall_pct  = 86;
        err_count      = 0;
        cycle_count    = 0;
        items_sent     = 0;
        frames_sent    = 0;
        bytes_seen     = 0;
        gen_fg         = 24'd0;
        gen_bg         = 24'd0;

        // Directed rows: typed bytes where obvious, predictor otherwise
        add_row(cte_pkg::FUNC_CELL, 8'h41, 24'h000000, 24'h000000, SHAPE_NONE,
                10'd0, 10'd0, 1, "\033[38;2;0;0;0m\033[48;2;0;0;0mA");
        add_row(cte_pkg::FUNC_CELL, 8'h42, 24'h000000, 24'h000000, SHAPE_NONE,
                10'd0, 10'd0, 1, "B");
        add_row(cte_pkg::FUNC_CELL, 8'h00, 24'h000000, 24'hFFFFFF, cte_pkg::SHAPE_BAR,
                10'd1023, 10'd1023, 0, "");
        add_row(cte_pkg::FUNC_BEGIN, 8'hFF, 24'hFFFFFF, 24'hFFFFFF, SHAPE_UNUSED,
                10'd1023, 10'd1023, 1, "\033[2J\033[1;1H");
        add_row(cte_pkg::FUNC_CELL, 8'hFF, 24'hFFFFFF, 24'hFFFFFF, SHAPE_NONE,
                10'd0, 10'd0, 1,
                "\033[38;2;255;255;255m\033[48;2;255;255;255m\377");
        add_row(cte_pkg::FUNC_CELL, 8'h1B, 24'hFFFFFF, 24'h000000, SHAPE_NONE,
                10'd0, 10'd0, 0, "");
        add_row(cte_pkg::FUNC_CELL, 8'h80, 24'h0A6409, 24'h63640A, SHAPE_NONE,
                10'd0, 10'd0, 0, "");
        add_row(FUNC_UNUSED, 8'hFF, 24'hFFFFFF, 24'hFFFFFF, SHAPE_UNUSED, 10'd1023,
                10'd1023, 1, "");
        add_row(cte_pkg::FUNC_CELL, 8'h7F, 24'h0A6409, 24'h63640A, SHAPE_NONE,
                10'd0, 10'd0, 0, "");
        add_row(cte_pkg::FUNC_FINISH, 8'h00, 24'h000000, 24'h000000, SHAPE_NONE,
                10'd0, 10'd0, 1, "\033[1;1H");
        add_row(cte_pkg::FUNC_FINISH, 8'h55, 24'h123456, 24'h654321,
                cte_pkg::SHAPE_BLOCK, 10'd998, 10'd998, 1, "\033[2 q\033[999;999H");
        add_row(cte_pkg::FUNC_FINISH, 8'hAA, 24'hABCDEF, 24'hFEDCBA,
                cte_pkg::SHAPE_BAR, 10'd9, 10'd99, 1, "\033[6 q\033[100;10H");
        add_row(cte_pkg::FUNC_FINISH, 8'h00, 24'h000000, 24'h000000, SHAPE_UNUSED,
                10'd1023, 10'd1023, 1, "\033[1024;1024H");
        add_row(cte_pkg::FUNC_FINISH, 8'h00, 24'h000000, 24'h000000,
                cte_pkg::SHAPE_BLOCK, 10'd1023, 10'd0, 0, "");
        add_row(cte_pkg::FUNC_CELL, 8'h61, 24'h0A6409, 24'h63640A, SHAPE_NONE,
                10'd0, 10'd0, 0, "");
        add_row(cte_pkg::FUNC_BEGIN, 8'h00, 24'h000000, 24'h000000, SHAPE_NONE,
                10'd0, 10'd0, 1, "\033[2J\033[1;1H");
        add_row(FUNC_UNUSED, 8'h00, 24'h000000, 24'h000000, SHAPE_NONE, 10'd0, 10'd0,
                1, "");
        add_row(cte_pkg::FUNC_CELL, 8'h62, 24'h0A6409, 24'h63640A, SHAPE_NONE,
                10'd0, 10'd0, 0, "");
        add_row(cte_pkg::FUNC_CELL, 8'h20, 24'hFFFFFF, 24'h63640A, SHAPE_NONE,
                10'd0, 10'd0, 0, "");
        add_row(cte_pkg::FUNC_CELL, 8'h0A, 24'hFFFFFF, 24'h000001, SHAPE_NONE,
                10'd0, 10'd0, 0, "");
        add_row(cte_pkg::FUNC_CELL, 8'h7E, 24'h010203, 24'hC80000, SHAPE_NONE,
                10'd0, 10'd0, 0, "");

        // Hold reset, then release at a falling edge
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_items[r])
            drive_item(dir_items[r], dir_typed[r], dir_want[r]);

        run_random(100, 10, 86);
        run_random(100, 86, 10);
        run_random(100, 0, 0);
        i_valid <= 1'b0;

        // Drain what is owed, then watch for stray bytes
        while (pending_bytes_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Run covered %0d items in %0d frames, %0d output bytes, %0d cycles",
                 items_sent, frames_sent, bytes_seen, cycle_count);
        $display("Mismatches found: %0d", err_count);
        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/cte_pkg.sv
hw/rtl/cte_front.sv
hw/rtl/cte_fifo.sv
hw/rtl/cte_back.sv
hw/rtl/cell_to_ansi_truecolor_encoder.sv
verif/tb.sv
